// ----- rtl/battery_divider_average_charge_percent_unit_assert.svh -----
// Assertion macros for the battery divider average charge percent unit.
// Depends on nothing; included by the top level only.
`ifndef BATTERY_DIVIDER_AVERAGE_CHARGE_PERCENT_UNIT_ASSERT_SVH
`define BATTERY_DIVIDER_AVERAGE_CHARGE_PERCENT_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset
`define BDACP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BDACP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BDACP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BDACP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/bdacp_pkg.sv -----
// Shared types, constants and the percent mapping for the battery charge unit.
// Depends on nothing; imported by every module of the block.
package bdacp_pkg;

    // Field and register widths
    localparam int PIN_W    = 12;
    localparam int OHM_W    = 24;
    localparam int BAT_W    = 16;
    localparam int PCT_W    = 7;
    localparam int HIST_W   = 15;
    localparam int PROD_W   = PIN_W + OHM_W;
    localparam int ITER_W   = $clog2(PROD_W + 1);
    localparam int CFG_IDX_W = 2;

    localparam int WINDOW_DEF = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FULL_OHMS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_OHMS = CFG_IDX_W'(1);

    // Saturation limits and charge thresholds
    localparam logic [BAT_W-1:0]  BAT_MAX    = '1;
    localparam logic [HIST_W-1:0] HIST_MAX   = '1;
    localparam logic [HIST_W-1:0] MV_FULL    = HIST_W'(2350);
    localparam logic [HIST_W-1:0] MV_EMPTY   = HIST_W'(1950);
    localparam logic [HIST_W-3:0] PCT_OFFSET = (HIST_W-2)'(488);
    localparam logic [PCT_W-1:0]  PCT_FULL   = PCT_W'(100);
    localparam logic [PCT_W-1:0]  PCT_EMPTY  = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_SCALE,
        ST_STORE,
        ST_SUM,
        ST_AVG_START,
        ST_DIV_AVG,
        ST_DONE
    } bdacp_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_pin;
        logic div_start;
        logic div_avg;
        logic latch_bat;
        logic ring_write;
        logic sum_step;
        logic out_load;
    } bdacp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic sum_last;
        logic out_free;
    } bdacp_stat_t;

    // Map an averaged voltage to a charge percentage
    function automatic logic [PCT_W-1:0] pct_of(input logic [HIST_W-1:0] avg);
        logic [HIST_W-3:0] quarter;
        quarter = avg[HIST_W-1:2];
        if (avg >= MV_FULL) begin
            return PCT_FULL;
        end else if (avg <= MV_EMPTY) begin
            return PCT_EMPTY;
        end else if (quarter <= PCT_OFFSET) begin
            return PCT_EMPTY;
        end else begin
            return PCT_W'(quarter - PCT_OFFSET);
        end
    endfunction

endpackage

// ----- rtl/bdacp_div.sv -----
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
// Depends on bdacp_pkg.
module bdacp_div
    import bdacp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [OHM_W-1:0]  divisor,
    input  logic [ITER_W-1:0] iters,
    output logic              busy,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    logic [OHM_W:0]    rem_reg, rem_next;
    logic [PROD_W-1:0] dq_reg, dq_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [OHM_W:0]    shifted;
    logic [OHM_W+1:0]  trial;

    // Shift in the next dividend bit and try the subtraction
    assign shifted = {rem_reg[OHM_W-1:0], dq_reg[PROD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dq_next   = dividend;
            cnt_next  = iters;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[OHM_W+1]) begin
                rem_next = shifted;
                dq_next  = {dq_reg[PROD_W-2:0], 1'b0};
            end else begin
                rem_next = trial[OHM_W:0];
                dq_next  = {dq_reg[PROD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the partial remainder and quotient
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ----- rtl/bdacp_ctrl.sv -----
// Controller state machine: sequences scale, store, sum, average, output.
// Depends on bdacp_pkg.
module bdacp_ctrl
    import bdacp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  bdacp_stat_t stat,
    output bdacp_cmd_t  cmd
);

    bdacp_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_MUL;
            ST_MUL:       state_next = ST_DIV_SCALE;
            ST_DIV_SCALE: if (stat.div_done) state_next = ST_STORE;
            ST_STORE:     state_next = ST_SUM;
            ST_SUM:       if (stat.sum_last) state_next = ST_AVG_START;
            ST_AVG_START: state_next = ST_DIV_AVG;
            ST_DIV_AVG:   if (stat.div_done) state_next = ST_DONE;
            ST_DONE:      if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load_pin = in_valid;
            end
            ST_MUL:       cmd.div_start = 1'b1;
            ST_DIV_SCALE: cmd.latch_bat = stat.div_done;
            ST_STORE:     cmd.ring_write = 1'b1;
            ST_SUM:       cmd.sum_step = 1'b1;
            ST_AVG_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_avg   = 1'b1;
            end
            // Hold the sample count on the divisor while the average iterates
            ST_DIV_AVG:   cmd.div_avg = 1'b1;
            ST_DONE:      cmd.out_load = stat.out_free;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/bdacp_dp.sv -----
// Datapath: config registers, multiplier, shared divider, history ring,
// running sum and output register. Depends on bdacp_pkg and bdacp_div.
module bdacp_dp
    import bdacp_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [OHM_W-1:0]     cfg_data,
    input  logic [PIN_W-1:0]     pin_mv,
    input  logic                 out_stall,
    input  bdacp_cmd_t           cmd,
    output bdacp_stat_t          stat,
    output logic                 out_valid,
    output logic [BAT_W-1:0]     battery_mv,
    output logic [PCT_W-1:0]     percent
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = HIST_W + CNT_W;

    logic [OHM_W-1:0]  full_ohms_reg;
    logic [OHM_W-1:0]  output_ohms_reg;
    logic [PIN_W-1:0]  pin_reg;
    logic [BAT_W-1:0]  bat_reg;
    logic [HIST_W-1:0] hist_reg [WINDOW];
    logic [IDX_W-1:0]  slot_reg;
    logic              full_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              out_valid_reg;
    logic [BAT_W-1:0]  battery_mv_reg;
    logic [PCT_W-1:0]  percent_reg;

    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] div_dividend;
    logic [OHM_W-1:0]  div_divisor;
    logic [ITER_W-1:0] div_iters;
    logic [PROD_W-1:0] quotient;
    logic              div_busy;
    logic              div_done;
    logic [BAT_W-1:0]  bat_sat;
    logic [HIST_W-1:0] stored;
    logic              slot_wrap;
    logic              out_free;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_ohms_reg   <= OHM_W'(1);
            output_ohms_reg <= OHM_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FULL_OHMS:   full_ohms_reg   <= cfg_data;
                REG_OUTPUT_OHMS: output_ohms_reg <= cfg_data;
                default:         full_ohms_reg   <= full_ohms_reg;
            endcase
        end
    end

    // 12 x 24 product feeds the divider at start
    assign product = pin_reg * full_ohms_reg;

    // Select divider operands: scaling ratio or ring average
    always_comb
    begin
        if (cmd.div_avg) begin
            div_dividend = {sum_reg, {(PROD_W - SUM_W){1'b0}}};
            div_divisor  = OHM_W'(count_reg);
            div_iters    = ITER_W'(SUM_W);
        end else begin
            div_dividend = product;
            div_divisor  = output_ohms_reg;
            div_iters    = ITER_W'(PROD_W);
        end
    end

    bdacp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // Saturate the scaled voltage and the ring entry
    assign bat_sat   = (|quotient[PROD_W-1:BAT_W]) ? BAT_MAX : quotient[BAT_W-1:0];
    assign stored    = bat_reg[BAT_W-1] ? HIST_MAX : bat_reg[HIST_W-1:0];
    assign slot_wrap = (slot_reg == IDX_W'(WINDOW - 1));
    assign out_free  = !out_valid_reg || !out_stall;

    // Capture input sample and scaled voltage
    always_ff @(posedge clk)
    begin
        if (cmd.load_pin) begin
            pin_reg <= pin_mv;
        end
        if (cmd.latch_bat) begin
            bat_reg <= bat_sat;
        end
    end

    // History ring and fill tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                hist_reg[i] <= '0;
            end
            slot_reg  <= '0;
            full_reg  <= 1'b0;
            count_reg <= CNT_W'(1);
        end else if (cmd.ring_write) begin
            hist_reg[slot_reg] <= stored;
            if (slot_wrap) begin
                slot_reg  <= '0;
                full_reg  <= 1'b1;
                count_reg <= CNT_W'(WINDOW);
            end else begin
                slot_reg  <= slot_reg + IDX_W'(1);
                count_reg <= full_reg ? CNT_W'(WINDOW) : CNT_W'(slot_reg) + CNT_W'(1);
            end
        end
    end

    // Accumulate every ring entry, one per cycle; unwritten entries are zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
        end else if (cmd.ring_write) begin
            idx_reg <= '0;
        end else if (cmd.sum_step) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ring_write) begin
            sum_reg <= '0;
        end else if (cmd.sum_step) begin
            sum_reg <= sum_reg + SUM_W'(hist_reg[idx_reg]);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load) begin
            battery_mv_reg <= bat_reg;
            percent_reg    <= pct_of(quotient[HIST_W-1:0]);
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;
    assign stat.sum_last = (idx_reg == IDX_W'(WINDOW - 1));
    assign stat.out_free = out_free;

    assign out_valid  = out_valid_reg;
    assign battery_mv = battery_mv_reg;
    assign percent    = percent_reg;

endmodule

// ----- rtl/battery_divider_average_charge_percent_unit.sv -----
// Top level of the battery divider average charge percent unit.
// Depends on bdacp_pkg, bdacp_ctrl, bdacp_dp and the assertion macro header.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | in_valid / in_stall   | pin_mv[11:0]
//  out     | output    | out_valid / out_stall | battery_mv[15:0], percent[6:0]
//  cfg     | input     | cfg_we                | cfg_index[1:0], cfg_data[23:0]
//
// A transaction runs from the accepting cycle to the output load: the shared
// one-bit-per-cycle divider first forms the divider ratio, the ring sum then
// reads one entry per cycle, and the divider then forms the average; each
// division ends with a done report.
// Reset clears the ring, the fill state and sets both resistances to 1.
// A finished result waits in the output register; the next transaction is
// taken while it waits, and only a result ready before the previous one is
// taken holds the controller.
module battery_divider_average_charge_percent_unit
    import bdacp_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [OHM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIN_W-1:0]     pin_mv,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BAT_W-1:0]     battery_mv,
    output logic [PCT_W-1:0]     percent
);

`include "battery_divider_average_charge_percent_unit_assert.svh"

    bdacp_cmd_t  cmd;
    bdacp_stat_t stat;

    bdacp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdacp_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pin_mv     (pin_mv),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .battery_mv (battery_mv),
        .percent    (percent)
    );

    // An accepted transaction keeps the input side busy
    `BDACP_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after accept")
    // Never start the divider while it is iterating
    `BDACP_ASSERT_IMP(a_div_idle, clk, rst_n, cmd.div_start, !stat.div_busy, "divider restarted while busy")
    // A new result appears only through an output load
    `BDACP_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_valid), $past(cmd.out_load), "output valid without load")

endmodule
